@@ hw/rtl/msc_pkg.sv @@
`default_nettype none
package msc_pkg;

    localparam int RAM_BYTES_DEF = 65536;

    localparam int CMD_W = 2;
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_EXEC  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SETPC = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_HALT      = 3'd1;
    localparam logic [2:0] ST_UNKNOWN   = 3'd2;
    localparam logic [2:0] ST_OVF       = 3'd3;
    localparam logic [2:0] ST_UNALIGNED = 3'd4;
    localparam logic [2:0] ST_BOUNDS    = 3'd5;
    localparam logic [2:0] ST_PC        = 3'd6;

    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_SLTI    = 6'h0A;
    localparam logic [5:0] OP_SLTIU   = 6'h0B;
    localparam logic [5:0] OP_ANDI    = 6'h0C;
    localparam logic [5:0] OP_ORI     = 6'h0D;
    localparam logic [5:0] OP_XORI    = 6'h0E;
    localparam logic [5:0] OP_LUI     = 6'h0F;
    localparam logic [5:0] OP_LB      = 6'h20;
    localparam logic [5:0] OP_LH      = 6'h21;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_LBU     = 6'h24;
    localparam logic [5:0] OP_LHU     = 6'h25;
    localparam logic [5:0] OP_SB      = 6'h28;
    localparam logic [5:0] OP_SH      = 6'h29;
    localparam logic [5:0] OP_SW      = 6'h2B;
    localparam logic [5:0] OP_HALT    = 6'h3F;

    localparam logic [5:0] FN_SLL  = 6'h00;
    localparam logic [5:0] FN_SRL  = 6'h02;
    localparam logic [5:0] FN_SRA  = 6'h03;
    localparam logic [5:0] FN_ADD  = 6'h20;
    localparam logic [5:0] FN_ADDU = 6'h21;
    localparam logic [5:0] FN_SUB  = 6'h22;
    localparam logic [5:0] FN_SUBU = 6'h23;
    localparam logic [5:0] FN_AND  = 6'h24;
    localparam logic [5:0] FN_OR   = 6'h25;
    localparam logic [5:0] FN_XOR  = 6'h26;
    localparam logic [5:0] FN_NOR  = 6'h27;
    localparam logic [5:0] FN_SLT  = 6'h2A;
    localparam logic [5:0] FN_SLTU = 6'h2B;

    typedef enum logic [3:0] {
        ALU_ADD, ALU_SUB, ALU_AND, ALU_OR, ALU_XOR, ALU_NOR,
        ALU_SLT, ALU_SLTU, ALU_SLL, ALU_SRL, ALU_SRA, ALU_LUI
    } t_alu_op;

endpackage
`default_nettype wire

@@ hw/rtl/msc_ram.sv @@
`default_nettype none
module msc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ hw/rtl/msc_alu.sv @@
`default_nettype none
module msc_alu (
    input  msc_pkg::t_alu_op   i_op,
    input  wire logic [31:0]   i_x,
    input  wire logic [31:0]   i_y,
    input  wire logic [4:0]    i_shamt,
    output logic      [31:0]   o_res,
    output logic               o_ovf
);
    import msc_pkg::*;

    logic [31:0] sum;
    logic [31:0] dif;

    assign sum = i_x + i_y;
    assign dif = i_x - i_y;

    always_comb begin
        o_ovf = 1'b0;
        case (i_op)
            ALU_ADD: begin
                o_res = sum;
                o_ovf = (i_x[31] ^ sum[31]) & (i_y[31] ^ sum[31]);
            end
            ALU_SUB: begin
                o_res = dif;
                o_ovf = (i_x[31] ^ i_y[31]) & (i_x[31] ^ dif[31]);
            end
            ALU_AND:  o_res = i_x & i_y;
            ALU_OR:   o_res = i_x | i_y;
            ALU_XOR:  o_res = i_x ^ i_y;
            ALU_NOR:  o_res = ~(i_x | i_y);
            ALU_SLT:  o_res = {31'd0, $signed(i_x) < $signed(i_y)};
            ALU_SLTU: o_res = {31'd0, i_x < i_y};
            ALU_SLL:  o_res = i_y << i_shamt;
            ALU_SRL:  o_res = i_y >> i_shamt;
            ALU_SRA:  o_res = 32'($signed(i_y) >>> i_shamt);
            ALU_LUI:  o_res = {i_y[15:0], 16'd0};
            default:  o_res = 32'd0;
        endcase
    end
endmodule
`default_nettype wire

@@ hw/rtl/mips_subset_core_step_core.sv @@
`default_nettype none
// Small MIPS-I integer core stepped one transaction at a time: load a RAM word,
// execute one instruction, read a register, or set the pc. After reset the
// data RAM is swept to zero, one word per cycle, and no transaction is taken
// until the sweep ends. Each transaction then runs through a sequencer around
// one word-wide RAM with a single read and write port, a register file RAM read
// one port per cycle, and one shared ALU. A RAM word load is dropped when the
// address is beyond RAM. An execute step only reports the held status while
// stopped; otherwise it fetches the word at the pc, reads rs and rt, runs the
// ALU, then does any load or store. A pc beyond RAM skips all of these and a
// no-op word skips all but the fetch. Every access reads two words; a store
// writes the second back only when its bytes reach into it. A result is held until it is taken.
module mips_subset_core_step_core #(
    parameter int RAM_BYTES = msc_pkg::RAM_BYTES_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic [msc_pkg::CMD_W-1:0] i_opcode,
    input  wire logic [15:0]               i_address,
    input  wire logic [31:0]               i_data,
    input  wire logic [4:0]                i_reg_index,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic [2:0]                     o_status,
    output logic [31:0]                    o_pc_now,
    output logic [31:0]                    o_instr_word,
    output logic                           o_reg_written,
    output logic [4:0]                     o_dest_reg,
    output logic [31:0]                    o_dest_value,
    output logic [31:0]                    o_read_value
);
    import msc_pkg::*;

    localparam int WORDS = RAM_BYTES / 4;
    localparam int WAW   = $clog2(WORDS);
    localparam int BAW   = WAW + 2;
    localparam logic [31:0] RAM_TOP = 32'(RAM_BYTES);
    localparam logic [31:0] LIM_B   = RAM_TOP - 32'd1;
    localparam logic [31:0] LIM_H   = RAM_TOP - 32'd2;
    localparam logic [31:0] LIM_W   = RAM_TOP - 32'd4;

    typedef enum logic [12:0] {
        S_CLEAR = 13'b0000000000001,
        S_IDLE  = 13'b0000000000010,
        S_MRA   = 13'b0000000000100,
        S_MRB   = 13'b0000000001000,
        S_MRC   = 13'b0000000010000,
        S_MWA   = 13'b0000000100000,
        S_MWB   = 13'b0000001000000,
        S_REGA  = 13'b0000010000000,
        S_REGB  = 13'b0000100000000,
        S_REGC  = 13'b0001000000000,
        S_EXEC  = 13'b0010000000000,
        S_FIN   = 13'b0100000000000,
        S_OUT   = 13'b1000000000000
    } t_state;

    t_state r_state;
    logic [WAW-1:0]   r_clr;
    logic [CMD_W-1:0] r_cmd;
    logic [4:0]       r_ri;
    logic [31:0]      r_pc, r_npc, r_cur;
    logic             r_stopped;
    logic [2:0]       r_stop_st, r_pend;
    logic [31:0]      r_ins, r_a, r_b;
    logic [BAW-1:0]   r_maddr;
    logic [3:0]       r_mbe;
    logic             r_mwr, r_mfetch;
    logic [31:0]      r_mdata, r_lo, r_hi;
    logic [31:0]      r_rvalid;
    logic [4:0]       r_rsel;
    logic [2:0]       r_status;
    logic [31:0]      r_instr, r_dval, r_rval;
    logic             r_wr;
    logic [4:0]       r_dreg;

    // field decode
    logic [5:0]  op, fn;
    logic [4:0]  rs, rt, rd, sh;
    logic [31:0] imm, simm, br_tgt;
    assign op     = r_ins[31:26];
    assign fn     = r_ins[5:0];
    assign rs     = r_ins[25:21];
    assign rt     = r_ins[20:16];
    assign rd     = r_ins[15:11];
    assign sh     = r_ins[10:6];
    assign imm    = {16'd0, r_ins[15:0]};
    assign simm   = {{16{r_ins[15]}}, r_ins[15:0]};
    assign br_tgt = r_cur + 32'd4 + {simm[29:0], 2'b00};

    // byte RAM, word organised
    logic           ram_we;
    logic [WAW-1:0] ram_waddr, ram_raddr, mw;
    logic [31:0]    ram_wdata, ram_rdata;
    logic [1:0]     moff;
    logic [63:0]    old64, mask64, data64, new64;
    logic [7:0]     be8;
    logic [31:0]    rd32, ld_val;

    assign mw   = r_maddr[BAW-1:2];
    assign moff = r_maddr[1:0];
    assign be8  = {4'd0, r_mbe} << moff;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            mask64[i*8 +: 8] = {8{be8[i]}};
        end
    end

    assign old64  = (r_state == S_MRC) ? {ram_rdata, r_lo} : {r_hi, r_lo};
    assign data64 = {32'd0, r_mdata} << {moff, 3'b000};
    assign new64  = (old64 & ~mask64) | (data64 & mask64);
    assign rd32   = old64[{moff, 3'b000} +: 32];

    always_comb begin
        case (op)
            OP_LB:   ld_val = {{24{rd32[7]}}, rd32[7:0]};
            OP_LBU:  ld_val = {24'd0, rd32[7:0]};
            OP_LH:   ld_val = {{16{rd32[15]}}, rd32[15:0]};
            OP_LHU:  ld_val = {16'd0, rd32[15:0]};
            default: ld_val = rd32;
        endcase
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = mw;
        ram_wdata = new64[31:0];
        ram_raddr = mw;
        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = 32'd0;
            end
            S_MRB: ram_raddr = mw + WAW'(1);
            S_MWA: ram_we = 1'b1;
            S_MWB: begin
                ram_we    = |be8[7:4];
                ram_waddr = mw + WAW'(1);
                ram_wdata = new64[63:32];
            end
            default: ;
        endcase
    end

    msc_ram #(.WIDTH(32), .DEPTH(WORDS)) u_dram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // shared ALU and instruction decode
    t_alu_op     alu_op;
    logic [31:0] alu_y, alu_res;
    logic        alu_ovf;
    logic [2:0]  dec_st, ex_st;
    logic        dec_wr, chk_ovf, ex_wr, is_mem, mem_wr;
    logic [4:0]  ex_dst;
    logic [3:0]  mem_be;
    logic [31:0] mem_lim;
    logic [1:0]  mem_amask;

    msc_alu u_alu (
        .i_op    (alu_op),
        .i_x     (r_a),
        .i_y     (alu_y),
        .i_shamt (sh),
        .o_res   (alu_res),
        .o_ovf   (alu_ovf)
    );

    always_comb begin
        alu_op    = ALU_ADD;
        alu_y     = simm;
        dec_st    = ST_OK;
        dec_wr    = 1'b0;
        chk_ovf   = 1'b0;
        ex_dst    = rt;
        is_mem    = 1'b0;
        mem_wr    = 1'b0;
        mem_be    = 4'b1111;
        mem_lim   = LIM_W;
        mem_amask = 2'b11;
        case (op)
            OP_SPECIAL: begin
                alu_y  = r_b;
                ex_dst = rd;
                dec_wr = 1'b1;
                case (fn)
                    FN_SLL:  alu_op = ALU_SLL;
                    FN_SRL:  alu_op = ALU_SRL;
                    FN_SRA:  alu_op = ALU_SRA;
                    FN_ADD:  begin alu_op = ALU_ADD; chk_ovf = 1'b1; end
                    FN_ADDU: alu_op = ALU_ADD;
                    FN_SUB:  begin alu_op = ALU_SUB; chk_ovf = 1'b1; end
                    FN_SUBU: alu_op = ALU_SUB;
                    FN_AND:  alu_op = ALU_AND;
                    FN_OR:   alu_op = ALU_OR;
                    FN_XOR:  alu_op = ALU_XOR;
                    FN_NOR:  alu_op = ALU_NOR;
                    FN_SLT:  alu_op = ALU_SLT;
                    FN_SLTU: alu_op = ALU_SLTU;
                    default: begin
                        dec_st = ST_UNKNOWN;
                        dec_wr = 1'b0;
                    end
                endcase
            end
            OP_BEQ, OP_BNE: ;
            OP_ADDI:  begin dec_wr = 1'b1; chk_ovf = 1'b1; end
            OP_ADDIU: dec_wr = 1'b1;
            OP_SLTI:  begin dec_wr = 1'b1; alu_op = ALU_SLT; end
            OP_SLTIU: begin dec_wr = 1'b1; alu_op = ALU_SLTU; end
            OP_ANDI:  begin dec_wr = 1'b1; alu_op = ALU_AND; alu_y = imm; end
            OP_ORI:   begin dec_wr = 1'b1; alu_op = ALU_OR;  alu_y = imm; end
            OP_XORI:  begin dec_wr = 1'b1; alu_op = ALU_XOR; alu_y = imm; end
            OP_LUI:   begin dec_wr = 1'b1; alu_op = ALU_LUI; alu_y = imm; end
            OP_LB, OP_LBU, OP_SB: begin
                is_mem    = 1'b1;
                mem_wr    = (op == OP_SB);
                mem_be    = 4'b0001;
                mem_lim   = LIM_B;
                mem_amask = 2'b00;
            end
            OP_LH, OP_LHU, OP_SH: begin
                is_mem    = 1'b1;
                mem_wr    = (op == OP_SH);
                mem_be    = 4'b0011;
                mem_lim   = LIM_H;
                mem_amask = 2'b01;
            end
            OP_LW, OP_SW: begin
                is_mem = 1'b1;
                mem_wr = (op == OP_SW);
            end
            OP_HALT: dec_st = ST_HALT;
            default: dec_st = ST_UNKNOWN;
        endcase
    end

    assign ex_st = (chk_ovf && alu_ovf) ? ST_OVF : dec_st;
    assign ex_wr = dec_wr && !(chk_ovf && alu_ovf);

    // register file
    logic        wr_req, rf_we;
    logic [4:0]  wr_idx, rf_raddr;
    logic [31:0] wr_val, rf_rdata, rf_val;

    always_comb begin
        wr_req = 1'b0;
        wr_idx = ex_dst;
        wr_val = alu_res;
        if (r_state == S_EXEC) begin
            wr_req = ex_wr;
        end else if (r_state == S_MRC && !r_mwr && !r_mfetch) begin
            wr_req = 1'b1;
            wr_idx = rt;
            wr_val = ld_val;
        end
    end

    assign rf_we    = wr_req && (wr_idx != 5'd0);
    assign rf_raddr = (r_state == S_REGB) ? rt : ((r_cmd == CMD_READ) ? r_ri : rs);
    assign rf_val   = r_rvalid[r_rsel] ? rf_rdata : 32'd0;

    msc_ram #(.WIDTH(32), .DEPTH(32)) u_rf (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (wr_idx),
        .i_wdata (wr_val),
        .i_raddr (rf_raddr),
        .o_rdata (rf_rdata)
    );

    logic [31:0] addr32;
    logic [2:0]  fin_st;
    assign addr32 = {16'd0, i_address};
    assign fin_st = (r_pend == ST_OK && r_pc >= RAM_TOP) ? ST_PC : r_pend;

    always_ff @(posedge i_clk) begin
        r_rsel <= rf_raddr;
        if (rf_we) begin
            r_wr   <= 1'b1;
            r_dreg <= wr_idx;
            r_dval <= wr_val;
        end
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_pc      <= 32'd0;
            r_npc     <= 32'd4;
            r_stopped <= 1'b0;
            r_stop_st <= ST_OK;
            r_rvalid  <= 32'd0;
        end else begin
            if (rf_we) begin
                r_rvalid[wr_idx] <= 1'b1;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + WAW'(1);
                    if (r_clr == WAW'(WORDS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd    <= i_opcode;
                        r_ri     <= i_reg_index;
                        r_status <= r_stop_st;
                        r_instr  <= 32'd0;
                        r_wr     <= 1'b0;
                        r_dreg   <= 5'd0;
                        r_dval   <= 32'd0;
                        r_rval   <= 32'd0;
                        r_mbe    <= 4'b1111;
                        r_mfetch <= 1'b0;
                        r_mwr    <= 1'b0;
                        r_mdata  <= i_data;
                        case (i_opcode)
                            CMD_LOAD: begin
                                r_maddr <= addr32[BAW-1:0];
                                r_mwr   <= 1'b1;
                                r_state <= (addr32 > LIM_W) ? S_OUT : S_MRA;
                            end
                            CMD_READ: r_state <= S_REGA;
                            CMD_SETPC: begin
                                r_pc      <= addr32;
                                r_npc     <= addr32 + 32'd4;
                                r_stopped <= 1'b0;
                                r_stop_st <= ST_OK;
                                r_status  <= ST_OK;
                                r_state   <= S_OUT;
                            end
                            default: begin
                                if (r_stopped) begin
                                    r_state <= S_OUT;
                                end else begin
                                    r_cur    <= r_pc;
                                    r_pc     <= r_npc;
                                    r_npc    <= r_npc + 32'd4;
                                    r_ins    <= 32'd0;
                                    r_pend   <= ST_OK;
                                    r_maddr  <= r_pc[BAW-1:0];
                                    r_mfetch <= 1'b1;
                                    r_state  <= (r_pc > LIM_W) ? S_FIN : S_MRA;
                                end
                            end
                        endcase
                    end
                end
                S_MRA: r_state <= S_MRB;
                S_MRB: begin
                    r_lo    <= ram_rdata;
                    r_state <= S_MRC;
                end
                S_MRC: begin
                    r_hi <= ram_rdata;
                    if (r_mwr) begin
                        r_state <= S_MWA;
                    end else if (r_mfetch) begin
                        r_ins   <= rd32;
                        r_instr <= rd32;
                        r_pend  <= ST_OK;
                        r_state <= (rd32 == 32'd0) ? S_FIN : S_REGA;
                    end else begin
                        r_pend  <= ST_OK;
                        r_state <= S_FIN;
                    end
                end
                S_MWA: r_state <= S_MWB;
                S_MWB: r_state <= (r_cmd == CMD_LOAD) ? S_OUT : S_FIN;
                S_REGA: r_state <= S_REGB;
                S_REGB: begin
                    if (r_cmd == CMD_READ) begin
                        r_rval  <= rf_val;
                        r_state <= S_OUT;
                    end else begin
                        r_a     <= rf_val;
                        r_state <= S_REGC;
                    end
                end
                S_REGC: begin
                    r_b     <= rf_val;
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_pend  <= ex_st;
                    r_state <= S_FIN;
                    if ((op == OP_BEQ && r_a == r_b) || (op == OP_BNE && r_a != r_b)) begin
                        r_npc <= br_tgt;
                    end
                    if (is_mem) begin
                        if ((alu_res[1:0] & mem_amask) != 2'b00) begin
                            r_pend <= ST_UNALIGNED;
                        end else if (alu_res > mem_lim) begin
                            r_pend <= ST_BOUNDS;
                        end else begin
                            r_maddr  <= alu_res[BAW-1:0];
                            r_mbe    <= mem_be;
                            r_mwr    <= mem_wr;
                            r_mfetch <= 1'b0;
                            r_mdata  <= r_b;
                            r_state  <= S_MRA;
                        end
                    end
                end
                S_FIN: begin
                    r_status <= fin_st;
                    if (fin_st != ST_OK) begin
                        r_stopped <= 1'b1;
                        r_stop_st <= fin_st;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!i_out_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = (r_state == S_OUT);
    assign o_status      = r_status;
    assign o_pc_now      = r_pc;
    assign o_instr_word  = r_instr;
    assign o_reg_written = r_wr;
    assign o_dest_reg    = r_dreg;
    assign o_dest_value  = r_dval;
    assign o_read_value  = r_rval;
endmodule
`default_nettype wire

@@ tb/msc_step_checker.sv @@
`timescale 1ns / 100ps
module msc_step_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [15:0] i_address,
    input  wire logic [31:0] i_data,
    input  wire logic [4:0]  i_reg_index,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [2:0]  i_status,
    input  wire logic [31:0] i_pc_now,
    input  wire logic [31:0] i_instr_word,
    input  wire logic        i_reg_written,
    input  wire logic [4:0]  i_dest_reg,
    input  wire logic [31:0] i_dest_value,
    input  wire logic [31:0] i_read_value,
    output int               o_errors,
    output int               o_outstanding,
    output int               o_results
);
    import msc_pkg::*;

    localparam logic [31:0] RAM_TOP = 32'd65536;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] pc_now;
        logic [31:0] instr_word;
        logic        reg_written;
        logic [4:0]  dest_reg;
        logic [31:0] dest_value;
        logic [31:0] read_value;
    } t_step_result;

    logic [31:0] gpr [32];
    logic [7:0]  mem [65536];
    logic [31:0] pc_q, npc_q;
    logic        halted;
    logic [2:0]  held_status;
    logic        w_flag;
    logic [4:0]  w_reg;
    logic [31:0] w_val;

    t_step_result pending_q [$];
    int err_cnt = 0;
    int res_cnt = 0;

    initial begin
        o_errors = 0;
        o_outstanding = 0;
        o_results = 0;
    end

    function automatic logic [31:0] mem_word(input logic [31:0] a);
        logic [15:0] e;
        e = a[15:0];
        if (a > RAM_TOP - 32'd4) return 32'd0;
        return {mem[e + 16'd3], mem[e + 16'd2], mem[e + 16'd1], mem[e]};
    endfunction

    task automatic put_reg(input logic [4:0] r, input logic [31:0] v);
        if (r != 5'd0) begin
            gpr[r] = v;
            w_flag = 1'b1;
            w_reg = r;
            w_val = v;
        end
    endtask

    task automatic run_instr(input logic [31:0] ins, input logic [31:0] cur,
                             output logic [2:0] st);
        logic [5:0]  op, fn;
        logic [4:0]  rs, rt, rd, sh;
        logic [31:0] a, b, imm, simm, ea, r;
        logic signed [31:0] bs;
        logic [15:0] e;
        op = ins[31:26];
        fn = ins[5:0];
        rs = ins[25:21];
        rt = ins[20:16];
        rd = ins[15:11];
        sh = ins[10:6];
        a = gpr[rs];
        b = gpr[rt];
        bs = b;
        imm = {16'd0, ins[15:0]};
        simm = {{16{ins[15]}}, ins[15:0]};
        ea = a + simm;
        e = ea[15:0];
        st = ST_OK;
        case (op)
            OP_SPECIAL: begin
                case (fn)
                    FN_SLL:  put_reg(rd, b << sh);
                    FN_SRL:  put_reg(rd, b >> sh);
                    FN_SRA:  put_reg(rd, bs >>> sh);
                    FN_ADD: begin
                        r = a + b;
                        if (((a ^ r) & (b ^ r)) >> 31) st = ST_OVF;
                        else put_reg(rd, r);
                    end
                    FN_ADDU: put_reg(rd, a + b);
                    FN_SUB: begin
                        r = a - b;
                        if (((a ^ b) & (a ^ r)) >> 31) st = ST_OVF;
                        else put_reg(rd, r);
                    end
                    FN_SUBU: put_reg(rd, a - b);
                    FN_AND:  put_reg(rd, a & b);
                    FN_OR:   put_reg(rd, a | b);
                    FN_XOR:  put_reg(rd, a ^ b);
                    FN_NOR:  put_reg(rd, ~(a | b));
                    FN_SLT:  put_reg(rd, {31'd0, $signed(a) < $signed(b)});
                    FN_SLTU: put_reg(rd, {31'd0, a < b});
                    default: st = ST_UNKNOWN;
                endcase
            end
            OP_BEQ: if (a == b) npc_q = cur + 32'd4 + (simm << 2);
            OP_BNE: if (a != b) npc_q = cur + 32'd4 + (simm << 2);
            OP_ADDI: begin
                r = a + simm;
                if (((a ^ r) & (simm ^ r)) >> 31) st = ST_OVF;
                else put_reg(rt, r);
            end
            OP_ADDIU: put_reg(rt, a + simm);
            OP_SLTI:  put_reg(rt, {31'd0, $signed(a) < $signed(simm)});
            OP_SLTIU: put_reg(rt, {31'd0, a < simm});
            OP_ANDI:  put_reg(rt, a & imm);
            OP_ORI:   put_reg(rt, a | imm);
            OP_XORI:  put_reg(rt, a ^ imm);
            OP_LUI:   put_reg(rt, imm << 16);
            OP_LB, OP_LBU: begin
                if (ea >= RAM_TOP) st = ST_BOUNDS;
                else if (op == OP_LB) put_reg(rt, {{24{mem[e][7]}}, mem[e]});
                else put_reg(rt, {24'd0, mem[e]});
            end
            OP_LH, OP_LHU: begin
                if (ea[0]) st = ST_UNALIGNED;
                else if (ea > RAM_TOP - 32'd2) st = ST_BOUNDS;
                else if (op == OP_LH)
                    put_reg(rt, {{16{mem[e + 16'd1][7]}}, mem[e + 16'd1], mem[e]});
                else put_reg(rt, {16'd0, mem[e + 16'd1], mem[e]});
            end
            OP_LW: begin
                if (ea[1:0] != 2'd0) st = ST_UNALIGNED;
                else if (ea > RAM_TOP - 32'd4) st = ST_BOUNDS;
                else put_reg(rt, mem_word(ea));
            end
            OP_SB: begin
                if (ea >= RAM_TOP) st = ST_BOUNDS;
                else mem[e] = b[7:0];
            end
            OP_SH: begin
                if (ea[0]) st = ST_UNALIGNED;
                else if (ea > RAM_TOP - 32'd2) st = ST_BOUNDS;
                else begin
                    mem[e] = b[7:0];
                    mem[e + 16'd1] = b[15:8];
                end
            end
            OP_SW: begin
                if (ea[1:0] != 2'd0) st = ST_UNALIGNED;
                else if (ea > RAM_TOP - 32'd4) st = ST_BOUNDS;
                else begin
                    mem[e] = b[7:0];
                    mem[e + 16'd1] = b[15:8];
                    mem[e + 16'd2] = b[23:16];
                    mem[e + 16'd3] = b[31:24];
                end
            end
            OP_HALT: st = ST_HALT;
            default: st = ST_UNKNOWN;
        endcase
    endtask

    task automatic predict_step(output t_step_result res);
        logic [31:0] cur, ins;
        logic [2:0]  st;
        res = '0;
        w_flag = 1'b0;
        w_reg = 5'd0;
        w_val = 32'd0;
        ins = 32'd0;
        st = held_status;
        case (i_opcode)
            CMD_LOAD: begin
                if ({16'd0, i_address} <= RAM_TOP - 32'd4) begin
                    mem[i_address]         = i_data[7:0];
                    mem[i_address + 16'd1] = i_data[15:8];
                    mem[i_address + 16'd2] = i_data[23:16];
                    mem[i_address + 16'd3] = i_data[31:24];
                end
            end
            CMD_READ: res.read_value = gpr[i_reg_index];
            CMD_SETPC: begin
                pc_q = {16'd0, i_address};
                npc_q = pc_q + 32'd4;
                halted = 1'b0;
                held_status = ST_OK;
                st = ST_OK;
            end
            default: begin
                if (!halted) begin
                    cur = pc_q;
                    ins = mem_word(cur);
                    pc_q = npc_q;
                    npc_q = pc_q + 32'd4;
                    if (ins == 32'd0) st = ST_OK;
                    else run_instr(ins, cur, st);
                    if (st == ST_OK && pc_q >= RAM_TOP) st = ST_PC;
                    if (st != ST_OK) begin
                        halted = 1'b1;
                        held_status = st;
                    end
                end
            end
        endcase
        res.status = st;
        res.pc_now = pc_q;
        res.instr_word = ins;
        res.reg_written = w_flag;
        res.dest_reg = w_reg;
        res.dest_value = w_val;
    endtask

    task automatic cmp_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
        if (want !== got) begin
            err_cnt++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_step_result r;
        if (!i_rst_n) begin
            for (int i = 0; i < 32; i++) gpr[i] = 32'd0;
            for (int i = 0; i < 65536; i++) mem[i] = 8'd0;
            pc_q = 32'd0;
            npc_q = 32'd4;
            halted = 1'b0;
            held_status = ST_OK;
            pending_q.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                predict_step(r);
                pending_q.push_back(r);
            end
            if (i_out_valid && !i_out_stall) begin
                res_cnt++;
                if (pending_q.size() == 0) begin
                    err_cnt++;
                    $display("%0t: result with no transaction waiting, status %h pc %h",
                             $time, i_status, i_pc_now);
                end else begin
                    r = pending_q.pop_front();
                    cmp_field("status", {29'd0, r.status}, {29'd0, i_status});
                    cmp_field("pc_now", r.pc_now, i_pc_now);
                    cmp_field("instr_word", r.instr_word, i_instr_word);
                    cmp_field("reg_written", {31'd0, r.reg_written}, {31'd0, i_reg_written});
                    cmp_field("dest_reg", {27'd0, r.dest_reg}, {27'd0, i_dest_reg});
                    cmp_field("dest_value", r.dest_value, i_dest_value);
                    cmp_field("read_value", r.read_value, i_read_value);
                end
            end
        end
        o_errors <= err_cnt;
        o_outstanding <= pending_q.size();
        o_results <= res_cnt;
    end
endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
module testbench;
    import msc_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int ITEM_GOAL = 1800;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  opcode = CMD_LOAD;
    logic [15:0] address = 16'd0;
    logic [31:0] data = 32'd0;
    logic [4:0]  reg_index = 5'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  status;
    logic [31:0] pc_now, instr_word, dest_value, read_value;
    logic        reg_written;
    logic [4:0]  dest_reg;
    int          errors, outstanding, results;

    int cycles = 0;
    int n_sent = 0;
    int n_exec = 0;
    int n_restart = 0;
    int burst_left = 0;
    int stall_phase = 0;
    int stall_mode = 0;

    always #5 i_clk = ~i_clk;

    mips_subset_core_step_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_opcode(opcode), .i_address(address), .i_data(data), .i_reg_index(reg_index),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_status(status), .o_pc_now(pc_now), .o_instr_word(instr_word),
        .o_reg_written(reg_written), .o_dest_reg(dest_reg),
        .o_dest_value(dest_value), .o_read_value(read_value)
    );

    msc_step_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_opcode(opcode), .i_address(address), .i_data(data), .i_reg_index(reg_index),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_status(status), .i_pc_now(pc_now), .i_instr_word(instr_word),
        .i_reg_written(reg_written), .i_dest_reg(dest_reg),
        .i_dest_value(dest_value), .i_read_value(read_value),
        .o_errors(errors), .o_outstanding(outstanding), .o_results(results)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // receiver stall pattern: free-running, random, or heavy
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (stall_phase == 0) begin
                stall_phase <= $urandom_range(20, 200);
                stall_mode <= $urandom_range(0, 2);
            end else begin
                stall_phase <= stall_phase - 1;
            end
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                default: out_stall <= ($urandom_range(0, 1) == 0);
            endcase
        end
    end

    task automatic send(input logic [1:0] op, input logic [15:0] addr,
                        input logic [31:0] d, input logic [4:0] ri);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        opcode <= op;
        address <= addr;
        data <= d;
        reg_index <= ri;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        n_sent++;
        if (op == CMD_EXEC) n_exec++;
        if (op == CMD_SETPC) n_restart++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    function automatic logic [31:0] itype(input logic [5:0] op, input logic [4:0] rs,
                                          input logic [4:0] rt, input logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    function automatic logic [31:0] rtype(input logic [4:0] rs, input logic [4:0] rt,
                                          input logic [4:0] rd, input logic [4:0] sh,
                                          input logic [5:0] fn);
        return {OP_SPECIAL, rs, rt, rd, sh, fn};
    endfunction

    function automatic logic [4:0] pick_reg();
        if ($urandom_range(0, 3) == 0) return 5'($urandom_range(0, 31));
        return 5'($urandom_range(0, 7));
    endfunction

    function automatic logic [31:0] gen_instr();
        int k;
        logic [5:0] op, fn;
        logic [15:0] imm;
        k = $urandom_range(0, 99);
        if (k < 30) begin
            case ($urandom_range(0, 12))
                0: fn = FN_SLL;   1: fn = FN_SRL;   2: fn = FN_SRA;
                3: fn = FN_ADD;   4: fn = FN_ADDU;  5: fn = FN_SUB;
                6: fn = FN_SUBU;  7: fn = FN_AND;   8: fn = FN_OR;
                9: fn = FN_XOR;   10: fn = FN_NOR;  11: fn = FN_SLT;
                default: fn = FN_SLTU;
            endcase
            return rtype(pick_reg(), pick_reg(), pick_reg(), 5'($urandom), fn);
        end else if (k < 50) begin
            case ($urandom_range(0, 7))
                0: op = OP_ADDI;  1: op = OP_ADDIU; 2: op = OP_SLTI;
                3: op = OP_SLTIU; 4: op = OP_ANDI;  5: op = OP_ORI;
                6: op = OP_XORI;  default: op = OP_LUI;
            endcase
            return itype(op, pick_reg(), pick_reg(), 16'($urandom));
        end else if (k < 72) begin
            case ($urandom_range(0, 7))
                0: op = OP_LB;  1: op = OP_LBU; 2: op = OP_LH; 3: op = OP_LHU;
                4: op = OP_LW;  5: op = OP_SB;  6: op = OP_SH; default: op = OP_SW;
            endcase
            if ($urandom_range(0, 9) < 7) begin
                imm = 16'($urandom_range(0, 16'h7FFF));
                if ($urandom_range(0, 4) != 0) begin
                    if (op == OP_LW || op == OP_SW) imm[1:0] = 2'd0;
                    else if (op == OP_LH || op == OP_LHU || op == OP_SH) imm[0] = 1'b0;
                end
                return itype(op, 5'd0, pick_reg(), imm);
            end
            return itype(op, pick_reg(), pick_reg(), 16'($urandom));
        end else if (k < 84) begin
            op = ($urandom_range(0, 1) == 0) ? OP_BEQ : OP_BNE;
            return itype(op, pick_reg(), pick_reg(), 16'($urandom_range(0, 12) - 4));
        end else if (k < 87) begin
            return {OP_HALT, 26'($urandom)};
        end else if (k < 90) begin
            return {6'($urandom), 26'($urandom)};
        end else if (k < 94) begin
            return $urandom;
        end else if (k < 97) begin
            return rtype(pick_reg(), pick_reg(), pick_reg(), 5'($urandom), 6'($urandom));
        end
        return 32'd0;
    endfunction

    initial begin
        logic [15:0] base;
        int nw, ns;
        bit pressed;
        pressed = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed
        send(CMD_READ, 16'd0, 32'd0, 5'd0);
        send(CMD_LOAD, 16'd65533, 32'hFFFF_FFFF, 5'd31);
        send(CMD_LOAD, 16'd65532, 32'hFFFF_FFFF, 5'd0);
        send(CMD_LOAD, 16'd0, itype(OP_LUI, 5'd0, 5'd1, 16'h7FFF), 5'd0);
        send(CMD_LOAD, 16'd4, itype(OP_ORI, 5'd1, 5'd1, 16'hFFFF), 5'd0);
        send(CMD_LOAD, 16'd8, rtype(5'd0, 5'd1, 5'd0, 5'd0, FN_ADDU), 5'd0);
        send(CMD_LOAD, 16'd12, itype(OP_ADDI, 5'd1, 5'd2, 16'd1), 5'd0);
        repeat (5) send(CMD_EXEC, 16'd0, 32'd0, 5'd0);
        send(CMD_READ, 16'd0, 32'd0, 5'd1);
        send(CMD_SETPC, 16'd16, 32'd0, 5'd0);
        send(CMD_LOAD, 16'd16, itype(OP_LW, 5'd0, 5'd3, 16'd2), 5'd0);
        send(CMD_EXEC, 16'd0, 32'd0, 5'd0);
        send(CMD_SETPC, 16'd20, 32'd0, 5'd0);
        send(CMD_LOAD, 16'd20, itype(OP_LB, 5'd1, 5'd3, 16'd1), 5'd0);
        send(CMD_EXEC, 16'd0, 32'd0, 5'd0);
        send(CMD_SETPC, 16'd24, 32'd0, 5'd0);
        send(CMD_LOAD, 16'd24, {OP_HALT, 26'd0}, 5'd0);
        send(CMD_EXEC, 16'd0, 32'd0, 5'd0);
        send(CMD_SETPC, 16'd65535, 32'd0, 5'd0);
        send(CMD_EXEC, 16'd0, 32'd0, 5'd0);
        send(CMD_SETPC, 16'd32, 32'd0, 5'd0);
        send(CMD_EXEC, 16'd0, 32'd0, 5'd31);
        drain();

        // random: mostly short programs, some noise
        while (n_sent < ITEM_GOAL) begin
            if (!pressed && n_sent > ITEM_GOAL / 2) begin
                pressed = 1'b1;
                drain();
            end
            if ($urandom_range(0, 4) != 0) begin
                if ($urandom_range(0, 9) == 0) base = 16'hFFC0 + 16'($urandom_range(0, 15) * 4);
                else base = {14'($urandom), 2'b00};
                nw = $urandom_range(2, 10);
                send(CMD_SETPC, base, $urandom, 5'($urandom));
                for (int i = 0; i < nw; i++)
                    send(CMD_LOAD, base + 16'(4 * i), gen_instr(), 5'($urandom));
                ns = $urandom_range(1, nw + 3);
                for (int i = 0; i < ns; i++) begin
                    if ($urandom_range(0, 9) == 0)
                        send(CMD_READ, 16'($urandom), $urandom, pick_reg());
                    send(CMD_EXEC, 16'($urandom), $urandom, 5'($urandom));
                end
            end else begin
                repeat ($urandom_range(1, 4))
                    send(2'($urandom), 16'($urandom), $urandom, 5'($urandom));
            end
        end
        drain();
        repeat (40) @(posedge i_clk);

        $display("covered %0d transactions (%0d execute steps, %0d pc restarts), %0d results",
                 n_sent, n_exec, n_restart, results);
        if (errors == 0 && outstanding == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end
endmodule

@@ files.f @@
hw/rtl/msc_pkg.sv
hw/rtl/msc_ram.sv
hw/rtl/msc_alu.sv
hw/rtl/mips_subset_core_step_core.sv
tb/msc_step_checker.sv
tb/testbench.sv
